/* sv/lrmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_pkg
// Shared types and constants for the LED ramp mode controller: mode and
// event codes, register indexes, ramp ROM and battery thresholds.
// ----------------------------------------------------------------------------
package lrmc_pkg;

  typedef enum logic [2:0] {
    MODE_RAMP     = 3'd0,
    MODE_FROZEN   = 3'd1,
    MODE_TURBO    = 3'd2,
    MODE_FIXED    = 3'd3,
    MODE_CONFIG   = 3'd4,
    MODE_BATT     = 3'd5,
    MODE_BEACON   = 3'd6,
    MODE_OVERTURE = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    FUNC_COLD = 3'd0,
    FUNC_TAP  = 3'd1,
    FUNC_STEP = 3'd2,
    FUNC_WDT  = 3'd3,
    FUNC_BATT = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_FOUR_LEVEL     = 3'd0,
    CFG_MODE_MEMORY    = 3'd1,
    CFG_FREEZE_ON_END  = 3'd2,
    CFG_INVERT_RAMP    = 3'd3,
    CFG_STROBE_ON_BOOT = 3'd4,
    CFG_LOW_THRESHOLD  = 3'd5,
    CFG_CRIT_THRESHOLD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic four_level;
    logic invert_ramp;
  } duty_cfg_t;

  localparam int unsigned WEAR_SLOTS = 16;
  localparam int unsigned ROM_DEPTH  = 64;

  localparam logic [7:0] DUTY_FULL    = 8'd255;
  localparam logic [7:0] DUTY_DIM     = 8'd5;
  localparam logic [7:0] LEVEL_NONE   = 8'hFF;
  localparam logic [7:0] LOW_THR_RST  = 8'd136;
  localparam logic [7:0] CRIT_THR_RST = 8'd115;

  localparam logic [7:0] BAR2_MIN = 8'd151;
  localparam logic [7:0] BAR3_MIN = 8'd165;
  localparam logic [7:0] BAR4_MIN = 8'd174;

  localparam logic [3:0] TAP_TURBO  = 4'd3;
  localparam logic [3:0] TAP_BEACON = 4'd5;
  localparam logic [3:0] TAP_BATT   = 4'd6;
  localparam logic [3:0] TAP_CONFIG = 4'd10;
  localparam logic [3:0] TAP_HOLD   = 4'd9;

  localparam logic [7:0] TICK_TAP_CLEAR = 8'd2;
  localparam logic [5:0] TICK_CHECK     = 6'd4;

  localparam logic [7:0] RAMP_ROM [ROM_DEPTH] = '{
    8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd5,
    8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,
    8'd15,  8'd17,  8'd18,  8'd20,  8'd22,  8'd24,  8'd26,  8'd28,
    8'd31,  8'd33,  8'd36,  8'd39,  8'd42,  8'd45,  8'd48,  8'd51,
    8'd55,  8'd58,  8'd62,  8'd66,  8'd70,  8'd74,  8'd79,  8'd84,
    8'd88,  8'd93,  8'd99,  8'd104, 8'd109, 8'd115, 8'd121, 8'd127,
    8'd134, 8'd140, 8'd147, 8'd154, 8'd161, 8'd168, 8'd176, 8'd184,
    8'd192, 8'd200, 8'd209, 8'd217, 8'd226, 8'd236, 8'd245, 8'd255
  };

endpackage

/* sv/lrmc_duty.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_duty
// Steady PWM duty for a mode and level: ramp ROM lookup through
// elaboration-time level tables, fixed-level and inverted variants.
// ----------------------------------------------------------------------------
module lrmc_duty import lrmc_pkg::*; #(
  parameter int unsigned RAMP_DEPTH   = 64,
  parameter int unsigned FIXED_LEVELS = 4,
  parameter int unsigned LVL_N        = 64,
  parameter int unsigned LVL_W        = 6
) (
  input  mode_e            mode_i,
  input  logic [LVL_W-1:0] level_i,
  input  duty_cfg_t        cfg_i,
  output logic [7:0]       duty_o
);

  localparam int unsigned FIX_W = $clog2(FIXED_LEVELS);

  logic [7:0] norm_tab [LVL_N];
  logic [7:0] inv_tab  [LVL_N];
  logic [7:0] fix_norm [FIXED_LEVELS];
  logic [7:0] fix_inv  [FIXED_LEVELS];

  for (genvar l = 0; l < LVL_N; l++) begin : g_lvl
    localparam int unsigned LC = (l > RAMP_DEPTH - 1) ? RAMP_DEPTH - 1 : l;
    localparam int unsigned LN = LC * 63 / (RAMP_DEPTH - 1);
    localparam int unsigned LI = (RAMP_DEPTH - 1 - LC) * 63 / (RAMP_DEPTH - 1);
    assign norm_tab[l] = RAMP_ROM[LN];
    assign inv_tab[l]  = RAMP_ROM[LI];
  end

  for (genvar k = 0; k < FIXED_LEVELS; k++) begin : g_fix
    localparam int unsigned LK = k * (RAMP_DEPTH - 1) / (FIXED_LEVELS - 1);
    localparam int unsigned KN = LK * 63 / (RAMP_DEPTH - 1);
    localparam int unsigned KI = (RAMP_DEPTH - 1 - LK) * 63 / (RAMP_DEPTH - 1);
    assign fix_norm[k] = RAMP_ROM[KN];
    assign fix_inv[k]  = RAMP_ROM[KI];
  end

  logic [LVL_W-1:0] fix_k;
  logic [7:0]       lvl_duty;

  always_comb begin
    fix_k = (level_i >= LVL_W'(FIXED_LEVELS - 1)) ? LVL_W'(FIXED_LEVELS - 1) : level_i;
    if (cfg_i.four_level) begin
      lvl_duty = cfg_i.invert_ramp ? fix_inv[fix_k[FIX_W-1:0]] : fix_norm[fix_k[FIX_W-1:0]];
    end else begin
      lvl_duty = cfg_i.invert_ramp ? inv_tab[level_i] : norm_tab[level_i];
    end
    unique case (mode_i)
      MODE_RAMP, MODE_FROZEN, MODE_FIXED: duty_o = lvl_duty;
      MODE_TURBO, MODE_OVERTURE:          duty_o = DUTY_FULL;
      default:                            duty_o = DUTY_DIM;
    endcase
  end

endmodule

/* sv/led_ramp_mode_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_ramp_mode_controller
// Mode controller for a single-button LED light: power events, ramp steps,
// watchdog ticks and battery samples update mode and level state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per transaction;
//   each event produces exactly one result on the output channel
//   (out_valid_o / out_stall_i).
//   Events pass an input register, then the update logic writes the state
//   and the result register, which raises out_valid_o; while a held result
//   is stalled, the event waits in the input register.
//   One event per cycle is sustained while the receiver does not stall; the
//   limit is the single state update per cycle.
//   While the receiver stalls, the held result stays put and one more event
//   is taken into the input register; after that in_stall_o rises.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always ready and are
//   to be made only while no event is in flight; the block does not check.
//   Reset: ramping mode, level 0, ramping downward, counters clear, all
//   options off, thresholds 136 and 115, both channels empty.
// ----------------------------------------------------------------------------
module led_ramp_mode_controller import lrmc_pkg::*; #(
  parameter int unsigned RAMP_DEPTH   = 64,
  parameter int unsigned FIXED_LEVELS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] remembered_level_i,
  input  logic [3:0] next_slot_i,
  input  logic [7:0] voltage_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] mode_o,
  output logic [7:0] pwm_duty_o,
  output logic       output_on_o,
  output logic [5:0] level_o,
  output logic       save_request_o,
  output logic [3:0] save_slot_o,
  output logic       erase_slots_o,
  output logic       ramp_end_o,
  output logic       low_battery_o,
  output logic       battery_critical_o,
  output logic [2:0] battery_bars_o
);

  localparam int unsigned LVL_N = (RAMP_DEPTH > FIXED_LEVELS) ? RAMP_DEPTH : FIXED_LEVELS;
  localparam int unsigned LVL_W = $clog2(LVL_N);
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(RAMP_DEPTH - 1);

  // configuration
  logic       four_level_q, mode_memory_q, freeze_on_end_q, invert_ramp_q, strobe_on_boot_q;
  logic [7:0] low_thr_q, crit_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_level_q     <= 1'b0;
      mode_memory_q    <= 1'b0;
      freeze_on_end_q  <= 1'b0;
      invert_ramp_q    <= 1'b0;
      strobe_on_boot_q <= 1'b0;
      low_thr_q        <= LOW_THR_RST;
      crit_thr_q       <= CRIT_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FOUR_LEVEL:     four_level_q     <= cfg_data_i[0];
        CFG_MODE_MEMORY:    mode_memory_q    <= cfg_data_i[0];
        CFG_FREEZE_ON_END:  freeze_on_end_q  <= cfg_data_i[0];
        CFG_INVERT_RAMP:    invert_ramp_q    <= cfg_data_i[0];
        CFG_STROBE_ON_BOOT: strobe_on_boot_q <= cfg_data_i[0];
        CFG_LOW_THRESHOLD:  low_thr_q        <= cfg_data_i;
        CFG_CRIT_THRESHOLD: crit_thr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, s1_adv, s1_fire, in_acc;
  logic out_valid_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !s1_adv);
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  logic [2:0] func_q;
  logic [7:0] rlevel_q, volt_q;
  logic [3:0] slot_in_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= func_i;
      rlevel_q  <= remembered_level_i;
      slot_in_q <= next_slot_i;
      volt_q    <= voltage_i;
    end
  end

  // controller state
  mode_e            mode_q, mode_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [3:0]       tap_q, tap_d, wear_q, wear_d;
  logic             down_q, down_d, pend_q, pend_d, lock_q, lock_d;
  logic [7:0]       tick_q, tick_d;

  logic [LVL_W-1:0] next_fix [LVL_N];
  for (genvar l = 0; l < LVL_N; l++) begin : g_nfix
    localparam int unsigned NF = (l + 1) % FIXED_LEVELS;
    assign next_fix[l] = LVL_W'(NF);
  end

  logic             save_d, end_d, low_d;
  logic [2:0]       bars_d;
  logic [3:0]       tap_inc;
  logic [7:0]       tick_inc;
  logic             dir;
  logic [LVL_W-1:0] step_lvl;
  logic [LVL_W+7:0] rlevel_ext;
  mode_e            dflt_mode;

  always_comb begin
    mode_d     = mode_q;
    level_d    = level_q;
    tap_d      = tap_q;
    wear_d     = wear_q;
    down_d     = down_q;
    pend_d     = pend_q;
    lock_d     = lock_q;
    tick_d     = tick_q;
    save_d     = 1'b0;
    end_d      = 1'b0;
    low_d      = 1'b0;
    bars_d     = 3'd0;
    tap_inc    = tap_q + 4'd1;
    tick_inc   = tick_q + 8'd1;
    rlevel_ext = {{LVL_W{1'b0}}, rlevel_q};
    dir        = down_q;
    step_lvl   = level_q;
    dflt_mode  = four_level_q ? MODE_FIXED : (mode_memory_q ? MODE_FROZEN : MODE_RAMP);

    if (func_q == FUNC_COLD || func_q == FUNC_TAP) begin
      wear_d = (32'(slot_in_q) < WEAR_SLOTS) ? slot_in_q : 4'd0;
      tick_d = 8'd0;
      pend_d = 1'b0;
      lock_d = 1'b0;
    end

    unique case (func_q)
      FUNC_COLD: begin
        tap_d  = 4'd0;
        down_d = 1'b1;
        if (mode_memory_q && rlevel_q != LEVEL_NONE) begin
          level_d = (rlevel_q > 8'(RAMP_DEPTH - 1)) ? LVL_TOP : rlevel_ext[LVL_W-1:0];
        end else begin
          level_d = '0;
        end
        mode_d = strobe_on_boot_q ? MODE_OVERTURE : dflt_mode;
      end
      FUNC_TAP: begin
        tap_d = tap_inc;
        priority if (tap_inc == TAP_TURBO && !four_level_q) begin
          mode_d = MODE_TURBO;
        end else if (tap_inc == TAP_BATT) begin
          mode_d = MODE_BATT;
        end else if (tap_inc == TAP_BEACON) begin
          mode_d = MODE_BEACON;
        end else if (tap_inc == TAP_CONFIG) begin
          tap_d  = TAP_HOLD;
          mode_d = MODE_CONFIG;
        end else if (mode_q == MODE_RAMP || mode_q == MODE_TURBO) begin
          mode_d = MODE_FROZEN;
          save_d = mode_memory_q;
        end else if (mode_q == MODE_FROZEN) begin
          mode_d = MODE_RAMP;
        end else if (mode_q == MODE_FIXED) begin
          level_d = next_fix[level_q];
          save_d  = mode_memory_q;
        end else begin
          mode_d = dflt_mode;
        end
      end
      FUNC_STEP: begin
        if (!lock_q) begin
          if (mode_q == MODE_RAMP) begin
            priority if (level_q >= LVL_TOP) begin
              dir = 1'b1;
            end else if (level_q == '0) begin
              dir = 1'b0;
            end else begin
              dir = down_q;
            end
            step_lvl = dir ? level_q - LVL_W'(1) : level_q + LVL_W'(1);
            level_d  = step_lvl;
            down_d   = dir;
            if (step_lvl == LVL_TOP || step_lvl == '0) begin
              end_d = 1'b1;
              if (freeze_on_end_q) begin
                mode_d = MODE_FROZEN;
              end
            end
          end else if (mode_q == MODE_CONFIG) begin
            mode_d = dflt_mode;
          end
        end
      end
      FUNC_WDT: begin
        tick_d = tick_inc;
        if (tick_inc == TICK_TAP_CLEAR) begin
          tap_d = 4'd0;
        end
        if (tick_inc[5:0] == TICK_CHECK) begin
          pend_d = 1'b1;
        end
      end
      FUNC_BATT: begin
        if (!lock_q) begin
          if (mode_q == MODE_BATT) begin
            priority if (volt_q >= BAR4_MIN) begin
              bars_d = 3'd4;
            end else if (volt_q >= BAR3_MIN) begin
              bars_d = 3'd3;
            end else if (volt_q >= BAR2_MIN) begin
              bars_d = 3'd2;
            end else begin
              bars_d = 3'd1;
            end
          end
          if (pend_q) begin
            if (volt_q <= crit_thr_q) begin
              lock_d = 1'b1;
            end else if (volt_q <= low_thr_q) begin
              low_d = 1'b1;
            end
            pend_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // frozen always resumes downward
    if (mode_d == MODE_FROZEN && mode_d != mode_q) begin
      down_d = 1'b1;
    end
    if (func_q == FUNC_TAP && mode_d == MODE_FROZEN) begin
      down_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RAMP;
      level_q <= '0;
      tap_q   <= 4'd0;
      down_q  <= 1'b1;
      tick_q  <= 8'd0;
      pend_q  <= 1'b0;
      wear_q  <= 4'd0;
      lock_q  <= 1'b0;
    end else if (s1_fire) begin
      mode_q  <= mode_d;
      level_q <= level_d;
      tap_q   <= tap_d;
      down_q  <= down_d;
      tick_q  <= tick_d;
      pend_q  <= pend_d;
      wear_q  <= wear_d;
      lock_q  <= lock_d;
    end
  end

  // result register
  logic [7:0]       duty_d;
  duty_cfg_t        duty_cfg;
  logic [LVL_W+5:0] level_ext;

  assign duty_cfg.four_level  = four_level_q;
  assign duty_cfg.invert_ramp = invert_ramp_q;
  assign level_ext            = {6'd0, level_d};

  lrmc_duty #(
    .RAMP_DEPTH  (RAMP_DEPTH),
    .FIXED_LEVELS(FIXED_LEVELS),
    .LVL_N       (LVL_N),
    .LVL_W       (LVL_W)
  ) u_duty (
    .mode_i (mode_d),
    .level_i(level_d),
    .cfg_i  (duty_cfg),
    .duty_o (duty_d)
  );

  logic [2:0] r_mode_q, r_bars_q;
  logic [7:0] r_duty_q;
  logic [5:0] r_level_q;
  logic [3:0] r_slot_q;
  logic       r_save_q, r_erase_q, r_end_q, r_low_q, r_lock_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      r_mode_q  <= mode_d;
      r_duty_q  <= duty_d;
      r_level_q <= level_ext[5:0];
      r_save_q  <= save_d;
      r_slot_q  <= save_d ? wear_d : 4'd0;
      r_erase_q <= save_d && (wear_d == 4'd0);
      r_end_q   <= end_d;
      r_low_q   <= low_d;
      r_lock_q  <= lock_d;
      r_bars_q  <= bars_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = r_mode_q;
  assign pwm_duty_o         = r_duty_q;
  assign output_on_o        = !r_lock_q;
  assign level_o            = r_level_q;
  assign save_request_o     = r_save_q;
  assign save_slot_o        = r_slot_q;
  assign erase_slots_o      = r_erase_q;
  assign ramp_end_o         = r_end_q;
  assign low_battery_o      = r_low_q;
  assign battery_critical_o = r_lock_q;
  assign battery_bars_o     = r_bars_q;

  // checks
  a_save_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && save_request_o) |->
      (mode_o == MODE_FROZEN || mode_o == MODE_FIXED))
    else $error("save request outside frozen or fixed mode");

  a_end_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && end_d) |=> (level_q == '0 || level_q == LVL_TOP))
    else $error("ramp end away from either end of the ramp");

  a_bars_batt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && battery_bars_o != 3'd0) |-> (mode_o == MODE_BATT))
    else $error("battery bars reported outside battery check");

  a_lock_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && lock_q && func_q != FUNC_COLD && func_q != FUNC_TAP) |=>
      (lock_q && $stable(level_q) && $stable(mode_q)))
    else $error("state changed during lockout without a power event");

endmodule

/* tb/tb_led_ramp_mode_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_ramp_mode_controller
// Self-checking bench for the LED ramp mode controller. A short table of
// power, tap, ramp, watchdog and battery events runs first, then random event
// bursts under several option settings. Each result is compared field by field
// against a behavioral copy of the mode logic (typed rows: their own result),
// with random idle gaps on the event side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_led_ramp_mode_controller;
  import lrmc_pkg::*;

  localparam int unsigned FIXED_COUNT   = 4;
  localparam logic [5:0]  TOP_LEVEL     = 6'(ROM_DEPTH - 1);
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] duty;
    logic       on;
    logic [5:0] level;
    logic       save;
    logic [3:0] slot;
    logic       erase;
    logic       at_end;
    logic       low;
    logic       crit;
    logic [2:0] bars;
  } lamp_out_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rl;
    logic [3:0] slot;
    logic [7:0] volt;
    logic       typed;
    lamp_out_t  want;
  } lamp_evt_t;

  // Opening sequence with reset options; typed rows carry their own result.
  localparam lamp_evt_t DIRECTED [26] = '{
    '{FUNC_COLD, 8'hFF, 4'hF, 8'h00, 1'b1,
      '{MODE_RAMP, 8'd1, 1'b1, 6'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
    '{FUNC_STEP, 8'h00, 4'h0, 8'hFF, 1'b1,
      '{MODE_RAMP, 8'd1, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
    '{FUNC_WDT, 8'h5A, 4'h3, 8'hA5, 1'b0, '0},
    '{FUNC_WDT, 8'hA5, 4'hC, 8'h5A, 1'b0, '0},
    '{FUNC_WDT, 8'h00, 4'h0, 8'h00, 1'b0, '0},
    '{FUNC_WDT, 8'hFF, 4'hF, 8'hFF, 1'b0, '0},
    '{FUNC_BATT, 8'h12, 4'h1, 8'd115, 1'b1,
      '{MODE_RAMP, 8'd1, 1'b0, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0}},
    '{FUNC_STEP, 8'h34, 4'h2, 8'h80, 1'b0, '0},
    '{FUNC_BATT, 8'h56, 4'h4, 8'h00, 1'b0, '0},
    '{FUNC_UNUSED_LO, 8'hFF, 4'hF, 8'hFF, 1'b0, '0},
    '{FUNC_UNUSED_HI, 8'h00, 4'h0, 8'h00, 1'b0, '0},
    '{FUNC_TAP, 8'h40, 4'h0, 8'h11, 1'b0, '0},
    '{FUNC_TAP, 8'h3F, 4'h9, 8'h22, 1'b0, '0},
    '{FUNC_TAP, 8'h01, 4'h7, 8'h33, 1'b1,
      '{MODE_TURBO, 8'd255, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
    '{FUNC_TAP, 8'h80, 4'h8, 8'h44, 1'b0, '0},
    '{FUNC_TAP, 8'h7F, 4'h5, 8'h55, 1'b1,
      '{MODE_BEACON, 8'd5, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
    '{FUNC_TAP, 8'hC3, 4'hA, 8'h66, 1'b0, '0},
    '{FUNC_BATT, 8'h3C, 4'h6, 8'd255, 1'b1,
      '{MODE_BATT, 8'd5, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd4}},
    '{FUNC_BATT, 8'h99, 4'hB, 8'd150, 1'b1,
      '{MODE_BATT, 8'd5, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd1}},
    '{FUNC_BATT, 8'h66, 4'hD, 8'd151, 1'b0, '0},
    '{FUNC_BATT, 8'hE7, 4'hE, 8'd174, 1'b0, '0},
    '{FUNC_TAP, 8'h18, 4'h1, 8'h77, 1'b0, '0},
    '{FUNC_TAP, 8'h24, 4'h2, 8'h88, 1'b0, '0},
    '{FUNC_TAP, 8'h42, 4'h4, 8'h99, 1'b0, '0},
    '{FUNC_TAP, 8'h81, 4'h8, 8'hAA, 1'b1,
      '{MODE_CONFIG, 8'd5, 1'b1, 6'd1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
    '{FUNC_STEP, 8'hF0, 4'hF, 8'hBB, 1'b0, '0}
  };

  logic       clk_i;
  logic       rst_ni             = 1'b0;
  logic       cfg_valid_i        = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i        = '0;
  logic [7:0] cfg_data_i         = '0;
  logic       in_valid_i         = 1'b0;
  logic       in_stall_o;
  logic [2:0] func_i             = '0;
  logic [7:0] remembered_level_i = '0;
  logic [3:0] next_slot_i        = '0;
  logic [7:0] voltage_i          = '0;
  logic       out_valid_o;
  logic       out_stall_i        = 1'b0;
  logic [2:0] mode_o;
  logic [7:0] pwm_duty_o;
  logic       output_on_o;
  logic [5:0] level_o;
  logic       save_request_o;
  logic [3:0] save_slot_o;
  logic       erase_slots_o;
  logic       ramp_end_o;
  logic       low_battery_o;
  logic       battery_critical_o;
  logic [2:0] battery_bars_o;

  led_ramp_mode_controller #(
    .RAMP_DEPTH  (ROM_DEPTH),
    .FIXED_LEVELS(FIXED_COUNT)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .remembered_level_i(remembered_level_i),
    .next_slot_i       (next_slot_i),
    .voltage_i         (voltage_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_o            (mode_o),
    .pwm_duty_o        (pwm_duty_o),
    .output_on_o       (output_on_o),
    .level_o           (level_o),
    .save_request_o    (save_request_o),
    .save_slot_o       (save_slot_o),
    .erase_slots_o     (erase_slots_o),
    .ramp_end_o        (ramp_end_o),
    .low_battery_o     (low_battery_o),
    .battery_critical_o(battery_critical_o),
    .battery_bars_o    (battery_bars_o)
  );

  // Option shadow
  logic       opt_fixed  = 1'b0;
  logic       opt_memory = 1'b0;
  logic       opt_freeze = 1'b0;
  logic       opt_high   = 1'b0;
  logic       opt_strobe = 1'b0;
  logic [7:0] thr_low    = LOW_THR_RST;
  logic [7:0] thr_crit   = CRIT_THR_RST;

  // Light state shadow
  mode_e      cur_mode   = MODE_RAMP;
  logic [5:0] cur_level  = '0;
  logic [3:0] taps       = '0;
  logic       going_down = 1'b1;
  logic [7:0] ticks      = '0;
  logic       check_due  = 1'b0;
  logic [3:0] slot_reg   = '0;
  logic       locked     = 1'b0;

  lamp_out_t   lamp_due [$];
  int          faults     = 0;
  int unsigned sent_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned in_quiet   = 0;
  int unsigned out_quiet  = 0;
  int unsigned stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void set_mode(mode_e m);
    cur_mode = m;
    if (m == MODE_FROZEN) going_down = 1'b1;
  endfunction

  function automatic void set_default();
    if (opt_fixed) set_mode(MODE_FIXED);
    else if (opt_memory) set_mode(MODE_FROZEN);
    else set_mode(MODE_RAMP);
  endfunction

  function automatic logic [7:0] level_to_duty(logic [5:0] lvl);
    int unsigned idx;
    idx = lvl;
    if (opt_fixed) begin
      if (idx >= FIXED_COUNT) idx = FIXED_COUNT - 1;
      idx = idx * (ROM_DEPTH - 1) / (FIXED_COUNT - 1);
    end
    if (opt_high) idx = ROM_DEPTH - 1 - idx;
    return RAMP_ROM[idx];
  endfunction

  // Applies one event to the shadow state and returns the light's response.
  function automatic lamp_out_t advance_lamp(lamp_evt_t ev);
    lamp_out_t res;
    res = '0;
    case (ev.func)
      FUNC_COLD: begin
        slot_reg   = (ev.slot >= WEAR_SLOTS) ? 4'd0 : ev.slot;
        ticks      = '0;
        check_due  = 1'b0;
        locked     = 1'b0;
        taps       = '0;
        going_down = 1'b1;
        if (opt_memory && ev.rl != LEVEL_NONE)
          cur_level = (ev.rl > TOP_LEVEL) ? TOP_LEVEL : ev.rl[5:0];
        else
          cur_level = '0;
        if (opt_strobe) set_mode(MODE_OVERTURE);
        else set_default();
      end
      FUNC_TAP: begin
        slot_reg  = (ev.slot >= WEAR_SLOTS) ? 4'd0 : ev.slot;
        ticks     = '0;
        check_due = 1'b0;
        locked    = 1'b0;
        taps      = taps + 4'd1;
        if (taps == TAP_TURBO && !opt_fixed) set_mode(MODE_TURBO);
        else if (taps == TAP_BATT) set_mode(MODE_BATT);
        else if (taps == TAP_BEACON) set_mode(MODE_BEACON);
        else if (taps == TAP_CONFIG) begin
          taps = TAP_HOLD;
          set_mode(MODE_CONFIG);
        end else if (cur_mode == MODE_RAMP || cur_mode == MODE_TURBO) begin
          set_mode(MODE_FROZEN);
          res.save = opt_memory;
        end else if (cur_mode == MODE_FROZEN) begin
          set_mode(MODE_RAMP);
        end else if (cur_mode == MODE_FIXED) begin
          cur_level = 6'((cur_level + 1) % FIXED_COUNT);
          res.save  = opt_memory;
        end else begin
          set_default();
        end
      end
      FUNC_STEP: begin
        if (!locked) begin
          if (cur_mode == MODE_RAMP) begin
            if (cur_level >= TOP_LEVEL) going_down = 1'b1;
            else if (cur_level == '0) going_down = 1'b0;
            cur_level = going_down ? cur_level - 6'd1 : cur_level + 6'd1;
            if (cur_level == TOP_LEVEL || cur_level == '0) begin
              res.at_end = 1'b1;
              if (opt_freeze) set_mode(MODE_FROZEN);
            end
          end else if (cur_mode == MODE_CONFIG) begin
            set_default();
          end
        end
      end
      FUNC_WDT: begin
        ticks = ticks + 8'd1;
        if (ticks == TICK_TAP_CLEAR) taps = '0;
        if (ticks[5:0] == TICK_CHECK) check_due = 1'b1;
      end
      FUNC_BATT: begin
        if (!locked) begin
          if (cur_mode == MODE_BATT) begin
            if (ev.volt >= BAR4_MIN) res.bars = 3'd4;
            else if (ev.volt >= BAR3_MIN) res.bars = 3'd3;
            else if (ev.volt >= BAR2_MIN) res.bars = 3'd2;
            else res.bars = 3'd1;
          end
          if (check_due) begin
            if (ev.volt <= thr_crit) locked = 1'b1;
            else if (ev.volt <= thr_low) res.low = 1'b1;
            check_due = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.mode = cur_mode;
    case (cur_mode)
      MODE_RAMP, MODE_FROZEN, MODE_FIXED: res.duty = level_to_duty(cur_level);
      MODE_TURBO, MODE_OVERTURE:          res.duty = DUTY_FULL;
      default:                            res.duty = DUTY_DIM;
    endcase
    res.on    = !locked;
    res.level = cur_level;
    res.slot  = res.save ? slot_reg : 4'd0;
    res.erase = res.save && slot_reg == 4'd0;
    res.crit  = locked;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch of none.
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 2))
      0:       return LEVEL_NONE;
      1:       return 8'($urandom_range(0, 63));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_volt();
    case ($urandom_range(0, 3))
      0:       return 8'(thr_crit + $urandom_range(0, 2) - 1);
      1:       return 8'(thr_low + $urandom_range(0, 2) - 1);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(lamp_evt_t ev);
    int unsigned gap;
    lamp_out_t   res;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= ev.func;
    remembered_level_i <= ev.rl;
    next_slot_i        <= ev.slot;
    voltage_i          <= ev.volt;
    do @(posedge clk_i); while (in_stall_o);
    res = advance_lamp(ev);
    lamp_due.push_back(ev.typed ? ev.want : res);
    sent_cnt++;
  endtask

  task automatic send_event(logic [2:0] f);
    lamp_evt_t ev;
    ev      = '0;
    ev.func = f;
    ev.rl   = pick_level();
    ev.slot = 4'($urandom_range(0, 15));
    ev.volt = pick_volt();
    send_item(ev);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lamp_due.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FOUR_LEVEL:     opt_fixed  = data[0];
      CFG_MODE_MEMORY:    opt_memory = data[0];
      CFG_FREEZE_ON_END:  opt_freeze = data[0];
      CFG_INVERT_RAMP:    opt_high   = data[0];
      CFG_STROBE_ON_BOOT: opt_strobe = data[0];
      CFG_LOW_THRESHOLD:  thr_low    = data;
      CFG_CRIT_THRESHOLD: thr_crit   = data;
      default: ;
    endcase
  endtask

  // flags: [0] fixed, [1] memory, [2] freeze, [3] start high, [4] strobe
  task automatic load_settings(logic [4:0] flags, logic [7:0] low_thr, logic [7:0] crit_thr);
    write_reg(CFG_FOUR_LEVEL, {7'd0, flags[0]});
    write_reg(CFG_MODE_MEMORY, {7'd0, flags[1]});
    write_reg(CFG_FREEZE_ON_END, {7'd0, flags[2]});
    write_reg(CFG_INVERT_RAMP, {7'd0, flags[3]});
    write_reg(CFG_STROBE_ON_BOOT, {7'd0, flags[4]});
    write_reg(CFG_LOW_THRESHOLD, low_thr);
    write_reg(CFG_CRIT_THRESHOLD, crit_thr);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      faults++;
    end
  endtask

  task automatic check_result();
    lamp_out_t want;
    if (lamp_due.size() == 0) begin
      $display("%0t ns: unexpected transaction, mode %0d level %0d", $time, mode_o, level_o);
      faults++;
    end else begin
      want = lamp_due.pop_front();
      cmp("mode", 8'(want.mode), 8'(mode_o));
      cmp("pwm_duty", want.duty, pwm_duty_o);
      cmp("output_on", 8'(want.on), 8'(output_on_o));
      cmp("level", 8'(want.level), 8'(level_o));
      cmp("save_request", 8'(want.save), 8'(save_request_o));
      cmp("save_slot", 8'(want.slot), 8'(save_slot_o));
      cmp("erase_slots", 8'(want.erase), 8'(erase_slots_o));
      cmp("ramp_end", 8'(want.at_end), 8'(ramp_end_o));
      cmp("low_battery", 8'(want.low), 8'(low_battery_o));
      cmp("battery_critical", 8'(want.crit), 8'(battery_critical_o));
      cmp("battery_bars", 8'(want.bars), 8'(battery_bars_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(out_quiet);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results outstanding", $time, lamp_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    int unsigned kind;
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: load_settings(5'b11111, 8'hFF, 8'hFF);
        1: load_settings(5'b00000, 8'h00, 8'h00);
        2: load_settings(5'b00011, LOW_THR_RST, CRIT_THR_RST);
        3: load_settings(5'b00110, 8'd180, 8'd140);
        default: load_settings(5'($urandom_range(0, 31)), 8'($urandom_range(100, 200)),
                               8'($urandom_range(80, 160)));
      endcase
      phase_start = sent_cnt;
      while (sent_cnt - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) drain();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          send_event(FUNC_COLD);
        end else if (kind < 32) begin
          n = $urandom_range(1, 11);
          repeat (n) send_event(FUNC_TAP);
        end else if (kind < 55) begin
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
          repeat (n) send_event(FUNC_STEP);
        end else if (kind < 75) begin
          n = $urandom_range(1, 6);
          repeat (n) send_event(FUNC_WDT);
          send_event(FUNC_BATT);
        end else if (kind < 85) begin
          send_event(FUNC_BATT);
        end else begin
          send_event(3'($urandom_range(0, 7)));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (faults == 0 && lamp_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lrmc_pkg.sv
sv/lrmc_duty.sv
sv/led_ramp_mode_controller.sv
tb/tb_led_ramp_mode_controller.sv
